>>> src/assert_macros.svh
// Assertion helpers, clocked on the rising edge, masked while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> src/bmhpq_pkg.sv
package bmhpq_pkg;

    // Stream payload widths
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 80;
    localparam int FIELD_W   = 32;
    localparam int COUNT_W   = 7;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_UP_CMP = 6'b000010,
        S_POP_LD = 6'b000100,
        S_DN_CMP = 6'b001000,
        S_FIN    = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    // Result beat, lowest field last
    typedef struct packed {
        logic [5:0]         pad;
        t_status            status;
        logic               queue_empty;
        logic [COUNT_W-1:0] count;
        logic [FIELD_W-1:0] top_value;
        logic [FIELD_W-1:0] removed_value;
    } t_result;

endpackage

>>> src/binary_max_heap_priority_queue.sv
// Channel  | Dir | Signals                              | Content
// ---------+-----+--------------------------------------+---------------------------------
// s (cmd)  | in  | s_tvalid s_tready s_tdata s_tuser    | tdata: value[31:0]; tuser: op
// m (rsp)  | out | m_tvalid m_tready m_tdata            | removed, top, count, empty, status
//
// One command at a time. Push: S_UP_CMP per level walked, then S_FIN, S_DONE. Pop: S_POP_LD,
// S_DN_CMP per level walked, then S_FIN, S_DONE. Up to log2(CAPACITY) levels; each level is one
// read-compare-write on the heap RAM. Pop on empty, push on full, last-entry pop go to S_DONE.
// Reset (i_rst_n low, synchronous) empties the queue; RAM contents are not cleared.
// A waiting result holds the block in its last step; s_tready is high when idle.

`include "assert_macros.svh"

module binary_max_heap_priority_queue #(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [bmhpq_pkg::S_TDATA_W-1:0]  s_tdata,   // value[31:0]
    input  logic [bmhpq_pkg::S_TUSER_W-1:0]  s_tuser,   // op[0]: 0 push, 1 pop
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [bmhpq_pkg::M_TDATA_W-1:0]  m_tdata    // removed_value[31:0],
                                                         // top_value[63:32],
                                                         // count[70:64],
                                                         // queue_empty[71],
                                                         // status[73:72], zeros
);
    import bmhpq_pkg::*;

    localparam int AW = $clog2(CAPACITY);       // heap index width
    localparam int CW = $clog2(CAPACITY + 1);   // element count width

    // signed compare on stored patterns
    function automatic logic f_gt(logic [VALUE_WIDTH-1:0] a, logic [VALUE_WIDTH-1:0] b);
        return $signed(a) > $signed(b);
    endfunction

    // (p - 1) / 2
    function automatic logic [AW-1:0] f_parent(logic [AW-1:0] p);
        logic [AW-1:0] pm1;
        pm1 = p - AW'(1);
        return pm1 >> 1;
    endfunction

    // ------------------------------------------------------------------
    // State
    t_state                 r_state;
    logic [CW-1:0]          r_cnt;      // count after the current command
    logic [AW-1:0]          r_pos;      // hole position of the moving entry
    logic [VALUE_WIDTH-1:0] r_val;      // moving entry
    logic [VALUE_WIDTH-1:0] r_top;      // mirror of heap[0]
    logic [VALUE_WIDTH-1:0] r_removed;
    t_status                r_status;
    logic                   r_m_valid;
    t_result                r_m_data;

    // Heap RAM: one write port, two registered read ports
    logic [VALUE_WIDTH-1:0] r_heap [CAPACITY];
    logic [VALUE_WIDTH-1:0] r_rd_a;
    logic [VALUE_WIDTH-1:0] r_rd_b;
    logic                   w_we;
    logic [AW-1:0]          w_waddr;
    logic [VALUE_WIDTH-1:0] w_wdata;
    logic                   w_re_a;
    logic                   w_re_b;
    logic [AW-1:0]          w_raddr_a;
    logic [AW-1:0]          w_raddr_b;

    // ------------------------------------------------------------------
    // Input decode
    logic                   w_take;
    t_op                    w_op;
    logic [63:0]            w_in_wide;
    logic [VALUE_WIDTH-1:0] w_in_val;
    logic                   w_full;
    logic                   w_empty;
    logic [AW-1:0]          w_push_pos;
    logic [AW-1:0]          w_last_pos;
    logic [AW:0]            w_cnt_ext;

    assign s_tready   = (r_state == S_IDLE);
    assign w_take     = s_tvalid && s_tready;
    assign w_op       = t_op'(s_tuser[0]);
    assign w_in_wide  = 64'(s_tdata);
    assign w_in_val   = w_in_wide[VALUE_WIDTH-1:0];
    assign w_full     = (r_cnt == CW'(CAPACITY));
    assign w_empty    = (r_cnt == '0);
    assign w_push_pos = AW'(r_cnt);
    assign w_last_pos = AW'(r_cnt - CW'(1));
    assign w_cnt_ext  = (AW + 1)'(r_cnt);

    // Sift-up step: r_rd_a holds the parent of r_pos
    logic [AW-1:0] w_up_par;
    logic          w_up_go;

    assign w_up_par = f_parent(r_pos);
    assign w_up_go  = f_gt(r_val, r_rd_a);

    // Sift-down step: r_rd_a / r_rd_b hold left / right child of r_pos
    logic [AW:0]            w_lc_e;
    logic [AW:0]            w_rc_e;
    logic                   w_rc_ok;
    logic                   w_pick_r;
    logic [VALUE_WIDTH-1:0] w_cand_v;
    logic [AW-1:0]          w_cand_i;
    logic                   w_dn_go;
    logic [AW:0]            w_nlc_e;
    logic [AW:0]            w_nrc_e;
    logic                   w_dn_more;
    logic                   w_root_more;

    assign w_lc_e      = {r_pos, 1'b1};
    assign w_rc_e      = w_lc_e + (AW + 1)'(1);
    assign w_rc_ok     = (w_rc_e < w_cnt_ext);
    // left child wins ties
    assign w_pick_r    = w_rc_ok && f_gt(r_rd_b, r_rd_a);
    assign w_cand_v    = w_pick_r ? r_rd_b : r_rd_a;
    assign w_cand_i    = w_pick_r ? w_rc_e[AW-1:0] : w_lc_e[AW-1:0];
    assign w_dn_go     = f_gt(w_cand_v, r_val);
    assign w_nlc_e     = {w_cand_i, 1'b1};
    assign w_nrc_e     = w_nlc_e + (AW + 1)'(1);
    assign w_dn_more   = (w_nlc_e < w_cnt_ext);
    assign w_root_more = ((AW + 1)'(1) < w_cnt_ext);

    // ------------------------------------------------------------------
    // RAM port control. Reads and the write never hit the same entry in a
    // cycle: the next read is always two levels away from the written entry.
    always_comb begin
        w_re_a    = 1'b0;
        w_re_b    = 1'b0;
        w_raddr_a = '0;
        w_raddr_b = '0;
        w_we      = 1'b0;
        w_waddr   = r_pos;
        w_wdata   = r_val;
        unique case (r_state)
            S_IDLE: begin
                if (w_take && !w_empty) begin
                    if (w_op == OP_PUSH && !w_full) begin
                        w_re_a    = 1'b1;
                        w_raddr_a = f_parent(w_push_pos);
                    end else if (w_op == OP_POP) begin
                        w_re_a    = 1'b1;
                        w_raddr_a = w_last_pos;
                    end
                end
            end
            S_UP_CMP: begin
                if (w_up_go) begin
                    w_we    = 1'b1;
                    w_wdata = r_rd_a;
                    if (w_up_par != '0) begin
                        w_re_a    = 1'b1;
                        w_raddr_a = f_parent(w_up_par);
                    end
                end
            end
            S_POP_LD: begin
                // children of the root
                w_re_a    = 1'b1;
                w_re_b    = 1'b1;
                w_raddr_a = AW'(1);
                w_raddr_b = AW'(2);
            end
            S_DN_CMP: begin
                if (w_dn_go) begin
                    w_we    = 1'b1;
                    w_wdata = w_cand_v;
                    if (w_dn_more) begin
                        w_re_a    = 1'b1;
                        w_re_b    = 1'b1;
                        w_raddr_a = w_nlc_e[AW-1:0];
                        w_raddr_b = w_nrc_e[AW-1:0];
                    end
                end
            end
            S_FIN: begin
                w_we = 1'b1;
            end
            S_DONE: begin
                w_we = 1'b0;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_heap[w_waddr] <= w_wdata;
        end
        if (w_re_a) begin
            r_rd_a <= r_heap[w_raddr_a];
        end
        if (w_re_b) begin
            r_rd_b <= r_heap[w_raddr_b];
        end
    end

    // ------------------------------------------------------------------
    // Result formatting
    logic [63:0] w_top_wide;
    logic [63:0] w_rem_wide;
    logic [15:0] w_cnt_wide;
    t_result     w_result;

    assign w_top_wide = w_empty ? 64'd0 : 64'(r_top);
    assign w_rem_wide = 64'(r_removed);
    assign w_cnt_wide = 16'(r_cnt);

    always_comb begin
        w_result               = '0;
        w_result.removed_value = w_rem_wide[FIELD_W-1:0];
        w_result.top_value     = w_top_wide[FIELD_W-1:0];
        w_result.count         = w_cnt_wide[COUNT_W-1:0];
        w_result.queue_empty   = w_empty;
        w_result.status        = r_status;
    end

    // ------------------------------------------------------------------
    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            // in S_DONE the output register is handled below
            if (r_m_valid && m_tready && r_state != S_DONE) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        if (w_op == OP_PUSH) begin
                            r_removed <= '0;
                            if (w_full) begin
                                r_status <= ST_FULL;
                                r_state  <= S_DONE;
                            end else begin
                                r_status <= ST_OK;
                                r_cnt <= r_cnt + CW'(1);
                                r_pos <= w_push_pos;
                                r_val <= w_in_val;
                                r_state <= w_empty ? S_FIN : S_UP_CMP;
                            end
                        end else begin
                            if (w_empty) begin
                                r_status  <= ST_EMPTY;
                                r_removed <= '0;
                                r_state   <= S_DONE;
                            end else begin
                                r_status  <= ST_OK;
                                r_removed <= r_top;
                                r_cnt     <= r_cnt - CW'(1);
                                r_pos     <= '0;
                                if (r_cnt == CW'(1)) begin
                                    r_top   <= '0;
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= S_POP_LD;
                                end
                            end
                        end
                    end
                end
                S_UP_CMP: begin
                    if (w_up_go) begin
                        r_pos <= w_up_par;
                        if (w_up_par == '0) begin
                            r_state <= S_FIN;
                        end
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_POP_LD: begin
                    // last entry now moves from the root
                    r_val   <= r_rd_a;
                    r_state <= w_root_more ? S_DN_CMP : S_FIN;
                end
                S_DN_CMP: begin
                    if (w_dn_go) begin
                        if (r_pos == '0) begin
                            r_top <= w_cand_v;
                        end
                        r_pos <= w_cand_i;
                        if (!w_dn_more) begin
                            r_state <= S_FIN;
                        end
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (r_pos == '0) begin
                        r_top <= r_val;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_m_valid || m_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= w_result;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;

    // ------------------------------------------------------------------
    // Checks
    `ASSERT_IMPL(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(CAPACITY))
    `ASSERT_NEXT(a_take_busy, i_clk, i_rst_n, w_take, r_state != S_IDLE)
    `ASSERT_IMPL(a_full_cnt, i_clk, i_rst_n, r_state == S_DONE && r_status == ST_FULL, w_full)
    `ASSERT_IMPL(a_empty_top, i_clk, i_rst_n, r_m_valid && r_m_data.queue_empty,
                 r_m_data.top_value == '0 && r_m_data.status != ST_FULL)

endmodule

>>> tb/sv/tb_binary_max_heap_priority_queue.sv
module tb_binary_max_heap_priority_queue;

    import bmhpq_pkg::*;

    localparam int HEAP_CAP = 64;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // value[31:0]
    logic [S_TUSER_W-1:0] s_tuser;   // op[0]
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // removed[31:0], top[63:32], count[70:64],
                                     // empty[71], status[73:72], zero pad

    binary_max_heap_priority_queue #(
        .CAPACITY    (HEAP_CAP),
        .VALUE_WIDTH (32)
    ) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Shadow heap: same array layout and sift rules as the block
    logic [31:0] heap_model [HEAP_CAP];
    int          heap_size;

    // Results owed by the block, oldest first
    t_result     result_due_q[$];

    int          mism_cnt;
    int          idle_pct;   // sender: chance of an idle gap before a beat
    int          stall_pct;  // receiver: chance of tready low per cycle
    int          hold_req;   // long receiver hold-off, picked up by the receiver
    int          hold_left;
    t_result     got_beat;
    t_result     want_beat;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1000000;
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // Shadow heap
    // ------------------------------------------------------------------
    function automatic void heap_swap(input int a, input int b);
        logic [31:0] tmp;
        tmp           = heap_model[a];
        heap_model[a] = heap_model[b];
        heap_model[b] = tmp;
    endfunction

    // Apply one command to the shadow heap and return the beat it must produce
    function automatic t_result heap_apply(input t_op op, input logic [31:0] val);
        t_result r;
        int      pos;
        int      up;
        int      lc;
        int      rc;
        int      best;
        r = '0;
        r.status = ST_OK;
        if (op == OP_PUSH) begin
            if (heap_size >= HEAP_CAP) begin
                r.status = ST_FULL;   // value dropped, heap untouched
            end else begin
                heap_model[heap_size] = val;
                pos = heap_size;
                heap_size++;
                // climb only while strictly greater than the parent
                while (pos > 0) begin
                    up = (pos - 1) / 2;
                    if ($signed(heap_model[pos]) <= $signed(heap_model[up]))
                        break;
                    heap_swap(pos, up);
                    pos = up;
                end
            end
        end else if (heap_size == 0) begin
            r.status = ST_EMPTY;
        end else begin
            r.removed_value = heap_model[0];
            heap_size--;
            heap_model[0] = heap_model[heap_size];
            pos = 0;
            // sink toward the strictly larger child; left wins a tie
            while (2 * pos + 1 < heap_size) begin
                lc   = 2 * pos + 1;
                rc   = 2 * pos + 2;
                best = pos;
                if ($signed(heap_model[lc]) > $signed(heap_model[best]))
                    best = lc;
                if (rc < heap_size && $signed(heap_model[rc]) > $signed(heap_model[best]))
                    best = rc;
                if (best == pos)
                    break;
                heap_swap(pos, best);
                pos = best;
            end
        end
        r.top_value   = (heap_size > 0) ? heap_model[0] : '0;
        r.count       = 7'(heap_size);
        r.queue_empty = (heap_size == 0);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one command beat, with a random idle gap first; log the owed result
    // at the edge where the beat is taken. tvalid is left high for the next call.
    task automatic heap_send(input t_op op, input logic [31:0] val);
        if ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= val;
        do @(posedge i_clk); while (!s_tready);
        result_due_q = {result_due_q, heap_apply(op, val)};
    endtask

    // Sender pause: stop offering until every owed result has been seen
    task automatic heap_drain();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (result_due_q.size() != 0);
    endtask

    task automatic set_idling(input int idle, input int stall);
        idle_pct  = idle;
        stall_pct = stall;
    endtask

    // Mix of full-range values, a narrow band that forces ties, and the extremes
    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(0, 3)) inside
            0, 1:    v = $urandom;
            2:       v = 32'($urandom_range(0, 8)) - 32'd4;
            default: begin
                case ($urandom_range(0, 3))
                    0:       v = 32'h7fff_ffff;
                    1:       v = 32'h8000_0000;
                    2:       v = 32'h7fff_fffe;
                    default: v = 32'h8000_0001;
                endcase
            end
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Receiver side: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        m_tready  <= 1'b0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every taken beat against the oldest owed result
    // ------------------------------------------------------------------
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_tvalid && m_tready) begin
                got_beat = t_result'(m_tdata);
                if (result_due_q.size() == 0) begin
                    mism_cnt++;
                    if (mism_cnt <= 10)
                        $display("unexpected result beat: rm=%h top=%h cnt=%0d emp=%b st=%0d",
                                 got_beat.removed_value, got_beat.top_value,
                                 got_beat.count, got_beat.queue_empty, got_beat.status);
                end else begin
                    want_beat = result_due_q.pop_front();
                    if (got_beat.removed_value !== want_beat.removed_value ||
                        got_beat.top_value     !== want_beat.top_value     ||
                        got_beat.count         !== want_beat.count         ||
                        got_beat.queue_empty   !== want_beat.queue_empty   ||
                        got_beat.status        !== want_beat.status        ||
                        got_beat.pad           !== want_beat.pad) begin
                        mism_cnt++;
                        if (mism_cnt <= 10)
                            $display({"result mismatch: want rm=%h top=%h cnt=%0d emp=%b ",
                                      "st=%0d pad=%h / got rm=%h top=%h cnt=%0d emp=%b ",
                                      "st=%0d pad=%h"},
                                     want_beat.removed_value, want_beat.top_value,
                                     want_beat.count, want_beat.queue_empty,
                                     want_beat.status, want_beat.pad,
                                     got_beat.removed_value, got_beat.top_value,
                                     got_beat.count, got_beat.queue_empty,
                                     got_beat.status, got_beat.pad);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Pop on empty, extreme values, equal children, emptying and popping again
    task automatic test_extremes_and_ties();
        heap_send(OP_POP, 32'hffff_ffff);
        heap_send(OP_PUSH, 32'h0000_0000);
        heap_send(OP_PUSH, 32'h7fff_ffff);
        heap_send(OP_PUSH, 32'h8000_0000);
        heap_send(OP_PUSH, 32'hffff_ffff);
        heap_send(OP_PUSH, 32'h0000_0001);
        heap_send(OP_POP, 32'h0);
        heap_send(OP_POP, 32'h0);
        heap_send(OP_POP, 32'h0);
        heap_send(OP_PUSH, 32'd5);
        heap_send(OP_PUSH, 32'd5);
        heap_send(OP_PUSH, 32'd5);
        heap_send(OP_PUSH, 32'd3);
        heap_send(OP_PUSH, 32'd5);
        heap_send(OP_POP, 32'h0);
        heap_send(OP_POP, 32'h0);
        while (heap_size > 0)
            heap_send(OP_POP, $urandom);
        heap_send(OP_POP, 32'h5555_aaaa);
        heap_drain();
    endtask

    // Fill to capacity, push into the full store, then empty it past zero
    task automatic test_fill_to_capacity();
        while (heap_size < HEAP_CAP)
            heap_send(OP_PUSH, pick_value());
        heap_send(OP_PUSH, 32'h7fff_ffff);
        heap_send(OP_PUSH, 32'h8000_0000);
        heap_send(OP_PUSH, $urandom);
        while (heap_size > 0)
            heap_send(OP_POP, $urandom);
        heap_send(OP_POP, $urandom);
        heap_drain();
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering
    task automatic test_backpressure();
        set_idling(0, 0);
        hold_req = 300;
        repeat (24)
            heap_send(($urandom_range(0, 99) < 70) ? OP_PUSH : OP_POP, pick_value());
        heap_drain();
    endtask

    // Random commands in bands: push-heavy, pop-heavy, balanced
    task automatic test_random_mix(input int idle, input int stall, input int n_items);
        int   push_pct;
        t_op  op;
        set_idling(idle, stall);
        for (int i = 0; i < n_items; i++) begin
            case ((i / 16) % 3)
                0:       push_pct = 75;
                1:       push_pct = 30;
                default: push_pct = 50;
            endcase
            op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
            heap_send(op, pick_value());
        end
        heap_drain();
    endtask

    initial begin
        i_rst_n   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        heap_size = 0;
        mism_cnt  = 0;
        hold_req  = 0;
        set_idling(0, 0);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes_and_ties();
        set_idling(25, 25);
        test_fill_to_capacity();
        test_backpressure();
        test_random_mix(0, 0, 70);
        test_random_mix(46, 0, 70);
        test_random_mix(0, 46, 70);
        test_random_mix(25, 25, 70);

        // everything delivered; let any stray beat show up before the verdict
        set_idling(0, 0);
        repeat (20) @(posedge i_clk);
        if (mism_cnt == 0 && result_due_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
